// ===== rtl/core/u8d_pkg.sv =====
// Package for the UTF-8 stream decoder: widths, byte classes, codepoint
// limits and the result-pair type handed from the decode stage to the buffer.
// No dependencies.
package u8d_pkg;

  localparam int CP_W  = 21;
  localparam int MLV_W = 17;

  localparam logic [7:0] LEAD_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD_HI   = 8'hF4;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

  localparam logic [MLV_W-1:0] MIN_2B = 17'h00080;
  localparam logic [MLV_W-1:0] MIN_3B = 17'h00800;
  localparam logic [MLV_W-1:0] MIN_4B = 17'h10000;

  // Zero, one or two codepoints caused by one byte, in output order.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
  } res_pair_t;

endpackage

// ===== rtl/core/u8d_if.sv =====
// Valid/ready channel interfaces for the UTF-8 stream decoder:
// one for raw bytes, one for decoded codepoints. Depends on u8d_pkg.
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if import u8d_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] codepoint;
  logic            last_of_run;

  modport source (output valid, output codepoint, output last_of_run, input ready);
  modport sink   (input valid, input codepoint, input last_of_run, output ready);
endinterface

// ===== rtl/core/u8d_core.sv =====
// Input byte register, sequence state and the decode logic that turns one
// byte into zero, one or two codepoints. Depends on u8d_pkg.
module u8d_core import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_byte,
  input  logic      room,
  output logic      load,
  output res_pair_t res
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [CP_W-1:0]  partial_value, partial_value_next;
  logic [MLV_W-1:0] min_legal_value, min_legal_value_next;
  logic [1:0]       bytes_remaining, bytes_remaining_next;

  logic             adv;
  logic             is_lead;
  logic [CP_W-1:0]  open_pv;
  logic [MLV_W-1:0] open_mlv;
  logic [1:0]       open_br;
  logic [CP_W-1:0]  acc;
  logic [CP_W-1:0]  b_cp;
  logic             bad_value;

  assign adv      = s1_valid && room;
  assign in_ready = !s1_valid || adv;
  assign load     = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      min_legal_value <= '0;
      bytes_remaining <= '0;
    end else if (adv) begin
      partial_value   <= partial_value_next;
      min_legal_value <= min_legal_value_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  assign is_lead = (s1_byte >= LEAD_LO) && (s1_byte <= LEAD_HI);
  assign b_cp    = {{(CP_W-8){1'b0}}, s1_byte};
  assign acc     = {partial_value[CP_W-7:0], s1_byte[5:0]};
  assign bad_value = (acc < {{(CP_W-MLV_W){1'b0}}, min_legal_value}) || (acc > CP_MAX) ||
                     ((acc >= SURR_LO) && (acc <= SURR_HI));

  // Sequence opened by a lead byte.
  always_comb begin
    open_pv  = '0;
    open_mlv = '0;
    open_br  = 2'd0;
    priority if (s1_byte >= LEAD_LO && s1_byte <= LEAD2_HI) begin
      open_pv  = {{(CP_W-5){1'b0}}, s1_byte[4:0]};
      open_mlv = MIN_2B;
      open_br  = 2'd1;
    end else if (s1_byte >= LEAD3_LO && s1_byte <= LEAD3_HI) begin
      open_pv  = {{(CP_W-4){1'b0}}, s1_byte[3:0]};
      open_mlv = MIN_3B;
      open_br  = 2'd2;
    end else if (s1_byte >= LEAD4_LO && s1_byte <= LEAD_HI) begin
      open_pv  = {{(CP_W-3){1'b0}}, s1_byte[2:0]};
      open_mlv = MIN_4B;
      open_br  = 2'd3;
    end else begin
      open_pv  = '0;
    end
  end

  always_comb begin
    res                  = '0;
    partial_value_next   = '0;
    min_legal_value_next = '0;
    bytes_remaining_next = 2'd0;
    if (bytes_remaining != 2'd0) begin
      if (s1_byte[7:6] != CONT_TAG) begin
        // Broken sequence: replace, then handle the byte afresh.
        res.cp0 = CP_REPL;
        if (!s1_byte[7]) begin
          res.cnt = 2'd2;
          res.cp1 = b_cp;
        end else if (is_lead) begin
          res.cnt              = 2'd1;
          partial_value_next   = open_pv;
          min_legal_value_next = open_mlv;
          bytes_remaining_next = open_br;
        end else begin
          res.cnt = 2'd2;
          res.cp1 = CP_REPL;
        end
      end else if (bytes_remaining != 2'd1) begin
        partial_value_next   = acc;
        min_legal_value_next = min_legal_value;
        bytes_remaining_next = bytes_remaining - 2'd1;
      end else begin
        res.cnt = 2'd1;
        res.cp0 = bad_value ? CP_REPL : acc;
      end
    end else if (!s1_byte[7]) begin
      res.cnt = 2'd1;
      res.cp0 = b_cp;
    end else if (is_lead) begin
      partial_value_next   = open_pv;
      min_legal_value_next = open_mlv;
      bytes_remaining_next = open_br;
    end else begin
      res.cnt = 2'd1;
      res.cp0 = CP_REPL;
    end
  end

  a_adv_has_byte: assert property (@(posedge clk) disable iff (rst)
    load |-> s1_valid)
    else $error("decode stage advanced without a byte");

  a_never_three: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> res.cnt != 2'd3)
    else $error("decode produced more than two results");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !room) |=> (s1_valid && $stable(s1_byte) && $stable(bytes_remaining)))
    else $error("stalled byte or sequence state changed");

endmodule

// ===== rtl/core/u8d_outbuf.sv =====
// Result buffer: holds the up to two codepoints of one byte and hands them
// out one per cycle while the receiver is ready, marking the last. Depends on u8d_pkg.
module u8d_outbuf import u8d_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  res_pair_t       res,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] codepoint,
  output logic            last_of_run
);

  logic [1:0]      cnt;
  logic [CP_W-1:0] cp0;
  logic [CP_W-1:0] cp1;
  logic            pop;

  assign out_valid   = cnt != 2'd0;
  assign pop         = out_valid && out_ready;
  assign room        = (cnt == 2'd0) || ((cnt == 2'd1) && pop);
  assign codepoint   = cp0;
  assign last_of_run = cnt == 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
    if (load) begin
      cp0 <= res.cp0;
      cp1 <= res.cp1;
    end else if (pop) begin
      cp0 <= cp1;
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> room)
    else $error("result loaded over pending results");

  a_no_surrogate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((codepoint >= SURR_LO) && (codepoint <= SURR_HI)))
    else $error("surrogate codepoint emitted");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> codepoint <= CP_MAX)
    else $error("codepoint above range emitted");

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: one byte request in, zero to two codepoints out.
// A codepoint becomes valid once its final byte has passed the decode register
// and its result is loaded into the result buffer, which waits for room.
// Throughput: one byte per cycle while the receiver is ready; a byte that yields
// two codepoints holds the decode register while the result buffer drains.
// Reset (rst, synchronous) empties both stages and clears the sequence state.
module utf8_stream_decoder import u8d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  u8d_byte_if.sink    bytes,
  u8d_cp_if.source    codepoints
);

  res_pair_t res;
  logic      load;
  logic      room;

  u8d_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_ready (bytes.ready),
    .in_byte  (bytes.in_byte),
    .room     (room),
    .load     (load),
    .res      (res)
  );

  u8d_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .res         (res),
    .room        (room),
    .out_valid   (codepoints.valid),
    .out_ready   (codepoints.ready),
    .codepoint   (codepoints.codepoint),
    .last_of_run (codepoints.last_of_run)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for utf8_stream_decoder: feeds byte requests through the
// byte channel and checks every decoded codepoint against a built-in decoder.
// Depends on u8d_pkg, u8d_if.sv and the decoder RTL.
module tb_top;
  import u8d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 500;

  typedef struct {
    logic [7:0]  value;
    int unsigned phase;
    bit          drain;
  } byte_req_t;

  typedef struct {
    logic [CP_W-1:0] cp;
    logic            last;
  } cp_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8d_byte_if byte_ch ();
  u8d_cp_if   cp_ch ();

  utf8_stream_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .bytes      (byte_ch),
    .codepoints (cp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle and stall percentages per phase: none, sender, receiver, both.
  int unsigned send_idle_pct  [4] = '{0, 53, 0, 29};
  int unsigned recv_stall_pct [4] = '{0, 0, 53, 29};
  int unsigned cur_phase = 0;

  byte_req_t pending_bytes [$];
  cp_exp_t   cp_expected [$];
  int unsigned mismatches = 0;
  int unsigned random_count = 0;
  bit drain_pending = 1'b0;

  // Decoder state as seen by the predictor.
  logic [CP_W-1:0]  part_val = '0;
  logic [MLV_W-1:0] min_val  = '0;
  logic [1:0]       seq_left = '0;

  function automatic void clear_seq();
    part_val = '0;
    min_val  = '0;
    seq_left = '0;
  endfunction

  function automatic void push_cp(input logic [CP_W-1:0] cp);
    cp_exp_t e;
    e.cp   = cp;
    e.last = 1'b0;
    cp_expected.push_back(e);
  endfunction

  function automatic void open_seq(input logic [7:0] b);
    if (b <= LEAD2_HI) begin
      part_val = {16'd0, b[4:0]};
      min_val  = MIN_2B;
      seq_left = 2'd1;
    end else if (b <= LEAD3_HI) begin
      part_val = {17'd0, b[3:0]};
      min_val  = MIN_3B;
      seq_left = 2'd2;
    end else begin
      part_val = {18'd0, b[2:0]};
      min_val  = MIN_4B;
      seq_left = 2'd3;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    bit emitted;
    emitted = 1'b0;
    if (seq_left != 2'd0) begin
      if (b[7:6] != CONT_TAG) begin
        // Abort the open sequence, then handle the byte afresh.
        clear_seq();
        push_cp(CP_REPL);
        emitted = 1'b1;
        if (!b[7]) begin
          push_cp({13'd0, b});
        end else if (b >= LEAD_LO && b <= LEAD_HI) begin
          open_seq(b);
        end else begin
          push_cp(CP_REPL);
        end
      end else begin
        part_val = {part_val[CP_W-7:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          if (part_val < min_val || part_val > CP_MAX ||
              (part_val >= SURR_LO && part_val <= SURR_HI)) begin
            push_cp(CP_REPL);
          end else begin
            push_cp(part_val);
          end
          emitted = 1'b1;
          clear_seq();
        end
      end
    end else if (!b[7]) begin
      push_cp({13'd0, b});
      emitted = 1'b1;
    end else if (b >= LEAD_LO && b <= LEAD_HI) begin
      open_seq(b);
    end else begin
      push_cp(CP_REPL);
      emitted = 1'b1;
    end
    if (emitted) begin
      cp_expected[cp_expected.size()-1].last = 1'b1;
    end
  endfunction

  task automatic queue_byte(input logic [7:0] v, input int unsigned ph);
    byte_req_t r;
    r.value = v;
    r.phase = ph;
    r.drain = drain_pending;
    drain_pending = 1'b0;
    pending_bytes.push_back(r);
  endtask

  function automatic logic [7:0] rand_lead(input int unsigned len);
    case (len)
      2: return 8'($urandom_range(LEAD2_HI, LEAD_LO));
      3: return 8'($urandom_range(LEAD3_HI, LEAD3_LO));
      4: return 8'($urandom_range(LEAD_HI, LEAD4_LO));
      default: return 8'($urandom_range(127, 0));
    endcase
  endfunction

  // Driver: present the next request once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.in_byte <= '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.in_byte);
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (pending_bytes.size() != 0) begin
          cur_phase = pending_bytes[0].phase;
        end
        // Hold a drain-marked request until every expected codepoint is out.
        if (pending_bytes.size() == 0 ||
            (pending_bytes[0].drain && cp_expected.size() != 0) ||
            $urandom_range(99) < send_idle_pct[cur_phase]) begin
          byte_ch.valid <= 1'b0;
        end else begin
          byte_ch.valid   <= 1'b1;
          byte_ch.in_byte <= pending_bytes[0].value;
          void'(pending_bytes.pop_front());
        end
      end
    end
  end

  // Monitor: compare each accepted codepoint with the oldest expectation.
  always @(posedge clk) begin
    cp_exp_t e;
    if (rst) begin
      cp_ch.ready <= 1'b0;
    end else begin
      if (cp_ch.valid && cp_ch.ready) begin
        if (cp_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected codepoint %h last_of_run %b", $time,
                   cp_ch.codepoint, cp_ch.last_of_run);
        end else begin
          e = cp_expected.pop_front();
          if (cp_ch.codepoint !== e.cp) begin
            mismatches++;
            $display("%0t: codepoint expected %h actual %h", $time, e.cp,
                     cp_ch.codepoint);
          end
          if (cp_ch.last_of_run !== e.last) begin
            mismatches++;
            $display("%0t: last_of_run expected %b actual %b", $time, e.last,
                     cp_ch.last_of_run);
          end
        end
      end
      cp_ch.ready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("utf8_stream_decoder: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] directed_bytes [27] = '{
      8'h00, 8'h7F, 8'h80, 8'hFF,
      8'hC2, 8'h80,                  // smallest two-byte value
      8'hED, 8'hA0, 8'h80,           // surrogate
      8'hF4, 8'h8F, 8'hBF, 8'hBF,    // largest scalar
      8'hE0, 8'h80, 8'h80,           // overlong
      8'hF4, 8'h90, 8'h80, 8'h80,    // above 10FFFF
      8'hC2, 8'h41,                  // broken by ASCII
      8'hE1, 8'hC3, 8'hA9,           // broken by a new lead that completes
      8'hF1, 8'hF8                   // broken by an invalid byte
    };
    int unsigned blk, blk_len, blk_end, ph, len, k, v;

    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    cp_ch.ready     = 1'b0;

    foreach (directed_bytes[i]) begin
      queue_byte(directed_bytes[i], 0);
    end

    blk = 0;
    while (random_count < RANDOM_BYTES) begin
      ph = blk % 4;
      blk_len = $urandom_range(60, 30);
      blk_end = random_count + blk_len;
      drain_pending = 1'b1;
      while (random_count < blk_end) begin
        k = $urandom_range(99);
        if (k < 70) begin
          // lead byte with its full count of continuation bytes, random payload
          len = $urandom_range(4, 1);
          queue_byte(rand_lead(len), ph);
          random_count++;
          repeat (len - 1) begin
            queue_byte(8'($urandom_range(8'hBF, 8'h80)), ph);
            random_count++;
          end
        end else if (k < 85) begin
          // truncated sequence followed by a non-continuation byte
          len = $urandom_range(4, 2);
          queue_byte(rand_lead(len), ph);
          random_count++;
          repeat ($urandom_range(len - 2, 0)) begin
            queue_byte(8'($urandom_range(8'hBF, 8'h80)), ph);
            random_count++;
          end
          v = $urandom_range(191, 0);
          if (v >= 128) v += 64;
          queue_byte(8'(v), ph);
          random_count++;
        end else begin
          repeat ($urandom_range(3, 1)) begin
            queue_byte(8'($urandom_range(255, 0)), ph);
            random_count++;
          end
        end
      end
      blk++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge so driver and monitor updates have settled.
    do begin
      @(negedge clk);
    end while (pending_bytes.size() != 0 || byte_ch.valid || cp_expected.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && cp_expected.size() == 0) begin
      $display("utf8_stream_decoder: match");
    end else begin
      $display("utf8_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_if.sv
rtl/core/u8d_core.sv
rtl/core/u8d_outbuf.sv
rtl/core/utf8_stream_decoder.sv
tb/tb_top.sv
